FILE: hw/rtl/mmsf_pkg.sv
`default_nettype none
package mmsf_pkg;

  typedef enum logic [2:0] {
    ST_INIT     = 3'd0,
    ST_READY    = 3'd1,
    ST_MANUAL   = 3'd2,
    ST_RUNNING  = 3'd3,
    ST_STOPPING = 3'd4,
    ST_STOPPED  = 3'd5,
    ST_FAULT    = 3'd6,
    ST_EMERG    = 3'd7
  } mach_state_t;

  localparam logic [3:0] EV_UPDATE       = 4'd0;
  localparam logic [3:0] EV_JOG_ENTER    = 4'd1;
  localparam logic [3:0] EV_JOG_RETURN   = 4'd2;
  localparam logic [3:0] EV_START_DONE   = 4'd3;
  localparam logic [3:0] EV_START_FAULT  = 4'd4;
  localparam logic [3:0] EV_SHUT_BEGIN   = 4'd5;
  localparam logic [3:0] EV_SHUT_END     = 4'd6;
  localparam logic [3:0] EV_MOTION_START = 4'd7;
  localparam logic [3:0] EV_MOTION_DONE  = 4'd8;
  localparam logic [3:0] EV_SEQ_BEGIN    = 4'd9;
  localparam logic [3:0] EV_SEQ_DONE     = 4'd10;
  localparam logic [3:0] EV_SEQ_FAIL     = 4'd11;
  localparam logic [3:0] EV_MOTION_STOP  = 4'd12;
  localparam logic [3:0] EV_MOTION_ABORT = 4'd13;
  localparam logic [3:0] EV_RESET        = 4'd14;

  localparam logic [2:0] CMD_ENTER_READY  = 3'd1;
  localparam logic [2:0] CMD_ENTER_MANUAL = 3'd2;
  localparam logic [2:0] CMD_EXIT_MANUAL  = 3'd3;
  localparam logic [2:0] CMD_START        = 3'd4;

  localparam logic [1:0] RSN_EMERG      = 2'd0;
  localparam logic [1:0] RSN_SERVO      = 2'd1;
  localparam logic [1:0] RSN_COMM       = 2'd2;

  typedef struct packed {
    logic [3:0] mode;
    logic       stop_latched;
    logic [1:0] stop_reason;
    logic       link_valid;
    logic       drive_ready;
    logic       emergency_seen;
    logic       drive_fault_seen;
    logic [2:0] command_kind;
    logic       stop_ack;
    logic       jog_wanted;
    logic       motion_halted;
    logic       jogs_released;
  } mmsf_in_t;

  typedef struct packed {
    logic [2:0] machine_state;
    logic       owns_sequence;
    logic       accepted;
  } mmsf_out_t;

endpackage
`default_nettype wire

FILE: hw/rtl/machine_mode_safety_fsm.sv
`default_nettype none
// Machine mode controller.
// Input channel (in_valid / in_stall / in_data): one event per transfer,
// selected by in_data.mode, with the status inputs that the event reads.
// Output channel (out_valid / out_stall / out_data): one result per event,
// carrying the new machine state, the sequence-owned flag and whether a
// try or begin event was accepted.
// The event is decoded and the state updated in the cycle it is taken;
// its result appears in the output register in the next cycle.
// Throughput is one event per cycle when out_stall is low; the next event
// is taken in the same cycle a result leaves the single output register.
// While a result waits under out_stall, in_stall is raised and the state
// holds; nothing is lost or repeated.
// Reset (rst_n low, synchronous) sets the state to initializing, clears
// the sequence flag and empties the output register.
module machine_mode_safety_fsm (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire mmsf_pkg::mmsf_in_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output mmsf_pkg::mmsf_out_t       out_data
);
  import mmsf_pkg::*;

  mach_state_t state_r, state_nxt;
  mach_state_t upd_st;
  logic        seq_r, seq_nxt;
  logic        acc_nxt;
  logic        out_valid_r;
  mmsf_out_t   out_data_r;
  logic        in_take;

  assign in_stall  = out_valid_r & out_stall;
  assign in_take   = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // periodic update
  always_comb begin
    upd_st = state_r;
    if (in_data.stop_latched) begin
      if (in_data.stop_reason == RSN_EMERG) begin
        upd_st = ST_EMERG;
      end else if (in_data.stop_reason == RSN_SERVO ||
                   (in_data.stop_reason == RSN_COMM && !in_data.link_valid)) begin
        upd_st = ST_FAULT;
      end else begin
        upd_st = ST_STOPPED;
      end
    end else begin
      if (in_data.stop_ack &&
          (upd_st == ST_EMERG || upd_st == ST_FAULT || upd_st == ST_STOPPED)) begin
        upd_st = in_data.link_valid ? ST_READY : ST_STOPPED;
      end
      if (upd_st == ST_INIT && in_data.link_valid) begin
        upd_st = ST_READY;
      end
      case (in_data.command_kind)
        CMD_ENTER_READY: begin
          if (upd_st == ST_STOPPED && in_data.link_valid) upd_st = ST_READY;
        end
        CMD_ENTER_MANUAL: begin
          if (upd_st == ST_READY) upd_st = ST_MANUAL;
        end
        CMD_EXIT_MANUAL: begin
          if (upd_st == ST_MANUAL) upd_st = ST_READY;
        end
        CMD_START: begin
          if (upd_st == ST_READY && in_data.link_valid && in_data.drive_ready)
            upd_st = ST_RUNNING;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    seq_nxt   = seq_r;
    acc_nxt   = 1'b0;
    case (in_data.mode)
      EV_UPDATE: state_nxt = upd_st;
      EV_JOG_ENTER: begin
        if (state_r == ST_READY && in_data.jog_wanted && in_data.motion_halted &&
            in_data.link_valid && !in_data.emergency_seen &&
            !in_data.drive_fault_seen) begin
          state_nxt = ST_MANUAL;
          acc_nxt   = 1'b1;
        end
      end
      EV_JOG_RETURN: begin
        if (state_r == ST_MANUAL && in_data.jogs_released && in_data.motion_halted) begin
          state_nxt = ST_READY;
          acc_nxt   = 1'b1;
        end
      end
      EV_START_DONE:  state_nxt = ST_READY;
      EV_START_FAULT: state_nxt = ST_FAULT;
      EV_SHUT_BEGIN:  state_nxt = ST_STOPPING;
      EV_SHUT_END:    state_nxt = ST_STOPPED;
      EV_MOTION_START: begin
        if (state_r == ST_READY || (seq_r && state_r == ST_RUNNING)) begin
          state_nxt = ST_RUNNING;
          acc_nxt   = 1'b1;
        end
      end
      EV_MOTION_DONE: begin
        if (state_r == ST_RUNNING && !seq_r) state_nxt = ST_READY;
      end
      EV_SEQ_BEGIN: begin
        if (state_r == ST_READY) begin
          seq_nxt   = 1'b1;
          state_nxt = ST_RUNNING;
          acc_nxt   = 1'b1;
        end
      end
      EV_SEQ_DONE: begin
        seq_nxt = 1'b0;
        if (state_r == ST_RUNNING || state_r == ST_STOPPING) state_nxt = ST_READY;
      end
      EV_SEQ_FAIL: begin
        seq_nxt   = 1'b0;
        state_nxt = ST_STOPPED;
      end
      EV_MOTION_STOP: begin
        if (state_r == ST_RUNNING) state_nxt = ST_STOPPING;
      end
      EV_MOTION_ABORT: begin
        if (state_r == ST_STOPPING) state_nxt = seq_r ? ST_RUNNING : ST_READY;
      end
      EV_RESET: begin
        state_nxt = ST_INIT;
        seq_nxt   = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      seq_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        state_r <= state_nxt;
        seq_r   <= seq_nxt;
      end
      if (in_take) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_data_r.machine_state <= state_nxt;
      out_data_r.owns_sequence <= seq_nxt;
      out_data_r.accepted      <= acc_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sim/machine_mode_safety_fsm_tb.sv
`default_nettype none
module machine_mode_safety_fsm_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mmsf_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned RAND_PER_PHASE = 360;
  localparam int unsigned MAX_PRINTS     = 30;
  localparam logic [3:0]  EV_UNUSED      = 4'd15;
  localparam logic [2:0]  CMD_UNUSED     = 3'd7;
  localparam logic [1:0]  RSN_OTHER      = 2'd3;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  mmsf_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  mmsf_out_t out_data;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;
  int unsigned events_sent    = 0;
  int unsigned results_checked = 0;
  int unsigned accepts_seen   = 0;
  int unsigned mismatches     = 0;
  logic [7:0]  states_seen    = '0;

  // predictor state
  mach_state_t mach_state = ST_INIT;
  logic        seq_owned  = 1'b0;
  mmsf_out_t   pending_outcomes[$];

  machine_mode_safety_fsm u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic mmsf_out_t apply_event(input mmsf_in_t ev);
    mach_state_t st;
    logic        acc;
    mmsf_out_t   res;
    st  = mach_state;
    acc = 1'b0;
    case (ev.mode)
      EV_UPDATE: begin
        if (ev.stop_latched) begin
          if (ev.stop_reason == RSN_EMERG)
            st = ST_EMERG;
          else if (ev.stop_reason == RSN_SERVO ||
                   (ev.stop_reason == RSN_COMM && !ev.link_valid))
            st = ST_FAULT;
          else
            st = ST_STOPPED;
        end else begin
          if (ev.stop_ack && (st == ST_EMERG || st == ST_FAULT || st == ST_STOPPED))
            st = ev.link_valid ? ST_READY : ST_STOPPED;
          if (st == ST_INIT && ev.link_valid)
            st = ST_READY;
          case (ev.command_kind)
            CMD_ENTER_READY:  if (st == ST_STOPPED && ev.link_valid) st = ST_READY;
            CMD_ENTER_MANUAL: if (st == ST_READY) st = ST_MANUAL;
            CMD_EXIT_MANUAL:  if (st == ST_MANUAL) st = ST_READY;
            CMD_START: begin
              if (st == ST_READY && ev.link_valid && ev.drive_ready) st = ST_RUNNING;
            end
            default: ;
          endcase
        end
      end
      EV_JOG_ENTER: begin
        if (st == ST_READY && ev.jog_wanted && ev.motion_halted && ev.link_valid &&
            !ev.emergency_seen && !ev.drive_fault_seen) begin
          st  = ST_MANUAL;
          acc = 1'b1;
        end
      end
      EV_JOG_RETURN: begin
        if (st == ST_MANUAL && ev.jogs_released && ev.motion_halted) begin
          st  = ST_READY;
          acc = 1'b1;
        end
      end
      EV_START_DONE:  st = ST_READY;
      EV_START_FAULT: st = ST_FAULT;
      EV_SHUT_BEGIN:  st = ST_STOPPING;
      EV_SHUT_END:    st = ST_STOPPED;
      EV_MOTION_START: begin
        if (st == ST_READY || (seq_owned && st == ST_RUNNING)) begin
          st  = ST_RUNNING;
          acc = 1'b1;
        end
      end
      EV_MOTION_DONE: if (st == ST_RUNNING && !seq_owned) st = ST_READY;
      EV_SEQ_BEGIN: begin
        if (st == ST_READY) begin
          seq_owned = 1'b1;
          st        = ST_RUNNING;
          acc       = 1'b1;
        end
      end
      EV_SEQ_DONE: begin
        seq_owned = 1'b0;
        if (st == ST_RUNNING || st == ST_STOPPING) st = ST_READY;
      end
      EV_SEQ_FAIL: begin
        seq_owned = 1'b0;
        st        = ST_STOPPED;
      end
      EV_MOTION_STOP: if (st == ST_RUNNING) st = ST_STOPPING;
      EV_MOTION_ABORT: begin
        if (st == ST_STOPPING) st = seq_owned ? ST_RUNNING : ST_READY;
      end
      EV_RESET: begin
        st        = ST_INIT;
        seq_owned = 1'b0;
      end
      default: ;
    endcase
    mach_state        = st;
    res.machine_state = st;
    res.owns_sequence = seq_owned;
    res.accepted      = acc;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < MAX_PRINTS)
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_outcomes.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      pending_outcomes.push_back(apply_event(in_data));
      events_sent++;
    end
  end

  always @(posedge clk) begin : check_results
    mmsf_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result with no event outstanding", out_data, 0);
      end else begin
        want = pending_outcomes.pop_front();
        if (out_data.machine_state !== want.machine_state)
          report_mismatch("machine_state", out_data.machine_state, want.machine_state);
        if (out_data.owns_sequence !== want.owns_sequence)
          report_mismatch("owns_sequence", out_data.owns_sequence, want.owns_sequence);
        if (out_data.accepted !== want.accepted)
          report_mismatch("accepted", out_data.accepted, want.accepted);
        results_checked++;
        states_seen[want.machine_state] = 1'b1;
        if (want.accepted) accepts_seen++;
      end
    end
  end

  task automatic send_event(input mmsf_in_t ev);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_outcomes.size() != 0);
  endtask

  function automatic mmsf_in_t plain_event(input logic [3:0] mode);
    mmsf_in_t ev;
    ev               = '0;
    ev.mode          = mode;
    ev.link_valid    = 1'b1;
    ev.drive_ready   = 1'b1;
    ev.jog_wanted    = 1'b1;
    ev.motion_halted = 1'b1;
    ev.jogs_released = 1'b1;
    return ev;
  endfunction

  function automatic mmsf_in_t random_event();
    mmsf_in_t    ev;
    int unsigned pick;
    ev   = '0;
    pick = $urandom_range(99);
    if (pick < 3)
      ev.mode = EV_UNUSED;
    else if (pick < 6)
      ev.mode = EV_RESET;
    else if (pick < 26)
      ev.mode = EV_UPDATE;
    else
      ev.mode = 4'($urandom_range(13, 1));
    ev.stop_latched     = ($urandom_range(99) < 12);
    ev.stop_reason      = 2'($urandom_range(3));
    ev.link_valid       = ($urandom_range(99) < 80);
    ev.drive_ready      = ($urandom_range(99) < 80);
    ev.emergency_seen   = ($urandom_range(99) < 15);
    ev.drive_fault_seen = ($urandom_range(99) < 15);
    ev.command_kind     = 3'($urandom_range(7));
    ev.stop_ack         = 1'($urandom_range(1));
    ev.jog_wanted       = ($urandom_range(99) < 75);
    ev.motion_halted    = ($urandom_range(99) < 75);
    ev.jogs_released    = ($urandom_range(99) < 75);
    return ev;
  endfunction

  task automatic test_update_path();
    mmsf_in_t ev;
    ev = '0;
    send_event(ev);
    ev = plain_event(EV_UPDATE);
    ev.command_kind = CMD_START;
    send_event(ev);
    ev = plain_event(EV_UPDATE);
    ev.stop_latched = 1'b1;
    ev.stop_reason  = RSN_EMERG;
    send_event(ev);
    ev.stop_reason = RSN_SERVO;
    send_event(ev);
    ev.stop_reason = RSN_COMM;
    ev.link_valid  = 1'b0;
    send_event(ev);
    // comm fault with a good link only stops
    ev.link_valid = 1'b1;
    send_event(ev);
    ev.stop_reason = RSN_OTHER;
    send_event(ev);
    ev = plain_event(EV_UPDATE);
    ev.stop_ack     = 1'b1;
    ev.link_valid   = 1'b0;
    ev.command_kind = CMD_ENTER_READY;
    send_event(ev);
    ev = plain_event(EV_UPDATE);
    ev.command_kind = CMD_ENTER_READY;
    send_event(ev);
    ev.command_kind = CMD_ENTER_MANUAL;
    send_event(ev);
    ev.command_kind = CMD_EXIT_MANUAL;
    send_event(ev);
    ev.command_kind = CMD_UNUSED;
    send_event(ev);
  endtask

  task automatic test_jog();
    send_event(plain_event(EV_JOG_ENTER));
    send_event(plain_event(EV_JOG_RETURN));
  endtask

  task automatic test_motion();
    send_event(plain_event(EV_MOTION_START));
    send_event(plain_event(EV_MOTION_DONE));
  endtask

  task automatic test_sequence();
    send_event(plain_event(EV_SEQ_BEGIN));
    send_event(plain_event(EV_MOTION_START));
    send_event(plain_event(EV_MOTION_STOP));
    send_event(plain_event(EV_MOTION_ABORT));
    send_event(plain_event(EV_SEQ_DONE));
    send_event(plain_event(EV_SEQ_FAIL));
  endtask

  task automatic test_lifecycle();
    send_event(plain_event(EV_START_FAULT));
    send_event(plain_event(EV_START_DONE));
    send_event(plain_event(EV_SHUT_BEGIN));
    send_event(plain_event(EV_SHUT_END));
    send_event('1);
    send_event(plain_event(EV_RESET));
  endtask

  task automatic test_random_events(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i == count / 2) wait_for_results();
      send_event(random_event());
    end
  endtask

  initial begin
    int unsigned directed_count;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct  = 22;
    recv_stall_pct = 52;
    test_update_path();
    test_jog();
    test_motion();
    test_sequence();
    test_lifecycle();
    wait_for_results();
    directed_count = events_sent;
    test_random_events(RAND_PER_PHASE);

    send_idle_pct  = 52;
    recv_stall_pct = 22;
    test_random_events(RAND_PER_PHASE);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_events(RAND_PER_PHASE);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d events (%0d directed) over three sender/receiver idle mixes.",
             events_sent, directed_count);
    $display("Checked %0d results, %0d tries accepted, states reached mask %b.",
             results_checked, accepts_seen, states_seen);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
